[design/mlse_pkg.sv]
`timescale 1ns / 1ps

package mlse_pkg;

    // Item kinds on the input side
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_EXEC  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    // Block status codes
    typedef enum logic [2:0] {
        ST_RUN = 3'd0,
        ST_RTS = 3'd1,
        ST_BAD = 3'd2,
        ST_OUT = 3'd3,
        ST_END = 3'd4,
        ST_CAP = 3'd5
    } t_status;

    // Number of data registers, fixed by the 3-bit register fields of the opcodes
    localparam int NUM_DATA_REGS = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENTRY = 2'd0;
    localparam logic [1:0] CFG_LEN   = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam logic [19:0] STEP_LIMIT_RST = 20'd100000;

    // Condition code bit positions
    localparam int CC_X = 4;
    localparam int CC_N = 3;
    localparam int CC_Z = 2;
    localparam int CC_V = 1;
    localparam int CC_C = 0;

    // Opcode masks and match patterns
    localparam logic [15:0] MOVEQ_MASK = 16'hF100;
    localparam logic [15:0] MOVEQ_PAT  = 16'h7000;
    localparam logic [15:0] SUBQ_MASK  = 16'hF1F8;
    localparam logic [15:0] SUBQ_PAT   = 16'h5180;
    localparam logic [15:0] ADD_MASK   = 16'hF1F8;
    localparam logic [15:0] ADD_PAT    = 16'hD080;
    localparam logic [15:0] BNE_MASK   = 16'hFF00;
    localparam logic [15:0] BNE_PAT    = 16'h6600;
    localparam logic [15:0] RTS_WORD   = 16'h4E75;

    // Register select value for the condition codes
    localparam logic [3:0] SEL_CCR = 4'd8;

    // Outcome of one executed opcode word
    typedef struct packed {
        logic          reg_we;
        logic [2:0]    reg_idx;
        logic [31:0]   reg_val;
        logic [4:0]    ccr;
        t_status       stop;
        logic          pass_inc;
        logic [15:0]   offset;
        logic [31:0]   pc;
    } t_exec_res;

endpackage

[design/mlse_alu.sv]
`timescale 1ns / 1ps

// Decodes one opcode word and works out register, flag and fetch updates.
module mlse_alu (
    input  logic [15:0]            i_word,
    input  logic [31:0]            i_val_hi,   // register at word bits 11:9
    input  logic [31:0]            i_val_lo,   // register at word bits 2:0
    input  logic [4:0]             i_ccr,
    input  logic [15:0]            i_offset,
    input  logic [31:0]            i_pc,
    input  logic [31:0]            i_entry,
    input  logic [15:0]            i_code_len,
    output mlse_pkg::t_exec_res    o_res
);

    logic [31:0] moveq_val;
    logic [31:0] subq_src;
    logic [32:0] sub_full;
    logic [32:0] add_full;
    logic [31:0] sub_res;
    logic [31:0] add_res;
    logic [17:0] br_tgt;
    logic        br_out;
    logic [15:0] seq_offset;

    function automatic logic [4:0] nz_bits(input logic [31:0] v);
        logic [4:0] f;
        f = '0;
        f[mlse_pkg::CC_N] = v[31];
        f[mlse_pkg::CC_Z] = (v == 32'd0);
        return f;
    endfunction

    // Datapath for each instruction
    assign moveq_val = {{24{i_word[7]}}, i_word[7:0]};
    assign subq_src  = (i_word[11:9] == 3'd0) ? 32'd8 : {29'd0, i_word[11:9]};
    assign sub_full  = {1'b0, i_val_lo} - {1'b0, subq_src};
    assign sub_res   = sub_full[31:0];
    assign add_full  = {1'b0, i_val_hi} + {1'b0, i_val_lo};
    assign add_res   = add_full[31:0];

    // Branch target relative to the word after the bne
    assign br_tgt = {2'b00, i_offset} + 18'd2 + {{10{i_word[7]}}, i_word[7:0]};
    assign br_out = br_tgt[17] || (br_tgt[16:0] >= {1'b0, i_code_len});

    assign seq_offset = i_offset + 16'd2;

    always_comb begin
        o_res          = '0;
        o_res.ccr      = i_ccr;
        o_res.stop     = mlse_pkg::ST_RUN;
        o_res.offset   = seq_offset;
        o_res.pc       = i_pc + 32'd2;
        o_res.reg_idx  = i_word[11:9];
        if ((i_word & mlse_pkg::MOVEQ_MASK) == mlse_pkg::MOVEQ_PAT) begin
            o_res.reg_we  = 1'b1;
            o_res.reg_val = moveq_val;
            o_res.ccr     = nz_bits(moveq_val);
            o_res.ccr[mlse_pkg::CC_X] = i_ccr[mlse_pkg::CC_X];
        end else if ((i_word & mlse_pkg::SUBQ_MASK) == mlse_pkg::SUBQ_PAT) begin
            o_res.reg_we  = 1'b1;
            o_res.reg_idx = i_word[2:0];
            o_res.reg_val = sub_res;
            o_res.ccr     = nz_bits(sub_res);
            o_res.ccr[mlse_pkg::CC_C] = sub_full[32];
            o_res.ccr[mlse_pkg::CC_X] = sub_full[32];
            o_res.ccr[mlse_pkg::CC_V] = (i_val_lo[31] ^ subq_src[31])
                                        & (i_val_lo[31] ^ sub_res[31]);
        end else if ((i_word & mlse_pkg::ADD_MASK) == mlse_pkg::ADD_PAT) begin
            o_res.reg_we  = 1'b1;
            o_res.reg_val = add_res;
            o_res.ccr     = nz_bits(add_res);
            o_res.ccr[mlse_pkg::CC_C] = add_full[32];
            o_res.ccr[mlse_pkg::CC_X] = add_full[32];
            o_res.ccr[mlse_pkg::CC_V] = ~(i_val_hi[31] ^ i_val_lo[31])
                                        & (i_val_hi[31] ^ add_res[31]);
        end else if ((i_word & mlse_pkg::BNE_MASK) == mlse_pkg::BNE_PAT) begin
            o_res.pass_inc = 1'b1;
            if (!i_ccr[mlse_pkg::CC_Z]) begin
                if (br_out) begin
                    o_res.stop   = mlse_pkg::ST_OUT;
                    o_res.offset = i_offset;
                    o_res.pc     = i_pc;
                end else begin
                    o_res.offset = br_tgt[15:0];
                    o_res.pc     = i_entry + {16'd0, br_tgt[15:0]};
                end
            end
        end else if (i_word == mlse_pkg::RTS_WORD) begin
            o_res.stop   = mlse_pkg::ST_RTS;
            o_res.offset = i_offset;
            o_res.pc     = i_pc;
        end else begin
            o_res.stop   = mlse_pkg::ST_BAD;
            o_res.offset = i_offset;
            o_res.pc     = i_pc;
        end
    end

endmodule

[design/m68k_loop_subset_executor_top.sv]
`timescale 1ns / 1ps

// Executes a small 68000 integer subset, one opcode word per input word.
// Input channel s_axis: tuser carries the item kind (start block, execute
// word, read register, write register); tdata carries the opcode word, the
// register select and the write value. Each input word yields exactly one
// output word on m_axis with the block status, next fetch offset, program
// counter, bne pass count, rts flag and read value. The caller fetches the
// opcode word at the reported offset and sends it back as the next item.
// The result is registered: it is in the output register the cycle
// after acceptance. Throughput is one word per cycle while not stalled; decode, the 32-bit
// add/subtract and the status checks sit between the architectural state
// and the output register. When the receiver stalls, the output register
// holds and s_axis_tready drops until the result is taken; a new word is
// accepted in the same cycle the held one leaves. Reset clears the data
// registers, condition codes, program counter, offset and counters, sets
// entry address and code length to zero and the step limit to 100000.
// Configuration writes on i_cfg_* land at once; issue them only when no word is in flight.
module m68k_loop_subset_executor_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [15:0] opcode_word, [19:16] reg_select, [51:20] write_value, rest zero
    input  logic [55:0]   s_axis_tdata,
    // [1:0] op
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [15:0] next_offset, [47:16] program_counter, [67:48] loop_passes,
    // [99:68] read_value, rest zero
    output logic [103:0]  m_axis_tdata,
    // [2:0] status, [3] rts flag
    output logic [3:0]    m_axis_tuser,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(mlse_pkg::NUM_DATA_REGS);

    // Configuration
    logic [31:0] r_entry;
    logic [15:0] r_code_len;
    logic [19:0] r_step_limit;

    // Architectural state
    logic [31:0]        r_dreg [mlse_pkg::NUM_DATA_REGS];
    logic [4:0]         r_ccr,    n_ccr;
    logic [31:0]        r_pc,     n_pc;
    logic [15:0]        r_offset, n_offset;
    logic [19:0]        r_steps,  n_steps;
    logic [19:0]        r_passes, n_passes;
    mlse_pkg::t_status  r_halt,   n_halt;

    // Output register
    logic               r_out_valid;
    logic [103:0]       r_out_data;
    logic [3:0]         r_out_user;

    logic               accept;
    mlse_pkg::t_op      in_op;
    logic [15:0]        in_word;
    logic [3:0]         in_sel;
    logic [31:0]        in_wval;
    logic [31:0]        n_rval;
    logic               n_reg_we;
    logic [IDX_W-1:0]   n_reg_idx;
    logic [31:0]        n_reg_val;
    mlse_pkg::t_status  pre_halt;
    logic [IDX_W-1:0]   port_a_idx;
    logic [31:0]        port_a_val;
    logic [31:0]        port_b_val;
    mlse_pkg::t_exec_res exec_res;

    assign in_op   = mlse_pkg::t_op'(s_axis_tuser);
    assign in_word = s_axis_tdata[15:0];
    assign in_sel  = s_axis_tdata[19:16];
    assign in_wval = s_axis_tdata[51:20];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Status check run after start, before and after each executed word
    function automatic mlse_pkg::t_status settle(
        input mlse_pkg::t_status st,
        input logic [15:0]       off,
        input logic [19:0]       steps,
        input logic [15:0]       len,
        input logic [19:0]       limit
    );
        mlse_pkg::t_status r;
        r = st;
        if (st == mlse_pkg::ST_RUN) begin
            if (({1'b0, off} + 17'd2) > {1'b0, len}) begin
                r = mlse_pkg::ST_END;
            end else if (steps >= limit) begin
                r = mlse_pkg::ST_CAP;
            end
        end
        return r;
    endfunction

    // Register file read ports: A serves reads and bits 11:9, B bits 2:0
    assign port_a_idx = (in_op == mlse_pkg::OP_READ) ? in_sel[IDX_W-1:0]
                                                     : in_word[11:9];
    assign port_a_val = r_dreg[port_a_idx];
    assign port_b_val = r_dreg[in_word[IDX_W-1:0]];

    assign pre_halt = settle(r_halt, r_offset, r_steps, r_code_len, r_step_limit);

    mlse_alu u_alu (
        .i_word     (in_word),
        .i_val_hi   (port_a_val),
        .i_val_lo   (port_b_val),
        .i_ccr      (r_ccr),
        .i_offset   (r_offset),
        .i_pc       (r_pc),
        .i_entry    (r_entry),
        .i_code_len (r_code_len),
        .o_res      (exec_res)
    );

    // Next state and result for the current input word
    always_comb begin
        n_ccr     = r_ccr;
        n_pc      = r_pc;
        n_offset  = r_offset;
        n_steps   = r_steps;
        n_passes  = r_passes;
        n_halt    = r_halt;
        n_rval    = 32'd0;
        n_reg_we  = 1'b0;
        n_reg_idx = in_sel[IDX_W-1:0];
        n_reg_val = in_wval;
        case (in_op)
            mlse_pkg::OP_START: begin
                n_offset = 16'd0;
                n_pc     = r_entry;
                n_steps  = 20'd0;
                n_passes = 20'd0;
                n_halt   = settle(mlse_pkg::ST_RUN, 16'd0, 20'd0,
                                  r_code_len, r_step_limit);
            end
            mlse_pkg::OP_EXEC: begin
                n_halt = pre_halt;
                if (pre_halt == mlse_pkg::ST_RUN) begin
                    n_steps   = r_steps + 20'd1;
                    n_reg_we  = exec_res.reg_we;
                    n_reg_idx = exec_res.reg_idx;
                    n_reg_val = exec_res.reg_val;
                    n_ccr     = exec_res.ccr;
                    n_offset  = exec_res.offset;
                    n_pc      = exec_res.pc;
                    n_passes  = r_passes + {19'd0, exec_res.pass_inc};
                    n_halt    = settle(exec_res.stop, exec_res.offset, n_steps,
                                       r_code_len, r_step_limit);
                end
            end
            mlse_pkg::OP_READ: begin
                if (in_sel < 4'(mlse_pkg::NUM_DATA_REGS)) begin
                    n_rval = port_a_val;
                end else if (in_sel == mlse_pkg::SEL_CCR) begin
                    n_rval = {27'd0, r_ccr};
                end
            end
            mlse_pkg::OP_WRITE: begin
                if (in_sel < 4'(mlse_pkg::NUM_DATA_REGS)) begin
                    n_reg_we = 1'b1;
                end else if (in_sel == mlse_pkg::SEL_CCR) begin
                    n_ccr = in_wval[4:0];
                end
            end
            default: begin
                n_halt = r_halt;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry      <= 32'd0;
            r_code_len   <= 16'd0;
            r_step_limit <= mlse_pkg::STEP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mlse_pkg::CFG_ENTRY: r_entry      <= i_cfg_data;
                mlse_pkg::CFG_LEN:   r_code_len   <= i_cfg_data[15:0];
                mlse_pkg::CFG_LIMIT: r_step_limit <= i_cfg_data[19:0];
                default: begin
                    r_entry <= r_entry;
                end
            endcase
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mlse_pkg::NUM_DATA_REGS; i++) begin
                r_dreg[i] <= 32'd0;
            end
        end else if (accept && n_reg_we) begin
            r_dreg[n_reg_idx] <= n_reg_val;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccr    <= 5'd0;
            r_pc     <= 32'd0;
            r_offset <= 16'd0;
            r_steps  <= 20'd0;
            r_passes <= 20'd0;
            r_halt   <= mlse_pkg::ST_RUN;
        end else if (accept) begin
            r_ccr    <= n_ccr;
            r_pc     <= n_pc;
            r_offset <= n_offset;
            r_steps  <= n_steps;
            r_passes <= n_passes;
            r_halt   <= n_halt;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {4'd0, n_rval, n_passes, n_pc, n_offset};
            r_out_user <= {(n_halt == mlse_pkg::ST_RTS), 3'(n_halt)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
